/* sv/tevq_pkg.sv */
// Shared types and constants for the timed event queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package tevq_pkg;

  // Queue sizing
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned MAX_OUT  = 16;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned RN_W     = $clog2(MAX_OUT + 1);

  // Command queue between front and back
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Field widths
  localparam int unsigned DUE_W = 32;
  localparam int unsigned TAG_W = 16;

  // Input action codes
  localparam logic [1:0] ACT_SCHED = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  // Result kinds
  localparam logic KIND_ACK = 1'b0;
  localparam logic KIND_REL = 1'b1;

  typedef enum logic [1:0] {
    OP_SCHED,
    OP_TICK,
    OP_CLOSE
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [DUE_W-1:0] due;
    logic [TAG_W-1:0] tag;
  } cmd_t;

endpackage

`default_nettype wire

/* sv/tevq_front.sv */
// Front end: accepts input beats, decodes the action, drops unused codes.
// Depends on tevq_pkg.
`default_nettype none

module tevq_front (
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            action_i,
  input  wire logic [31:0]           due_time_i,
  input  wire logic [15:0]           event_tag_i,
  input  wire logic                  q_full_i,
  output logic                       q_push_o,
  output tevq_pkg::cmd_t             q_cmd_o
);
  import tevq_pkg::*;

  logic accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  always_comb begin
    q_push_o     = 1'b0;
    q_cmd_o.op   = OP_SCHED;
    q_cmd_o.due  = due_time_i;
    q_cmd_o.tag  = event_tag_i;
    case (action_i)
      ACT_SCHED: begin
        q_push_o   = accept;
        q_cmd_o.op = OP_SCHED;
      end
      ACT_TICK: begin
        q_push_o   = accept;
        q_cmd_o.op = OP_TICK;
      end
      ACT_CLOSE: begin
        q_push_o   = accept;
        q_cmd_o.op = OP_CLOSE;
      end
      default: begin
        // unused code: swallow the beat
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* sv/tevq_fifo.sv */
// Short command queue between the front and back ends.
// Depends on tevq_pkg.
`default_nettype none

module tevq_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tevq_pkg::cmd_t  push_cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output tevq_pkg::cmd_t       pop_cmd_o,
  output logic                 empty_o
);
  import tevq_pkg::*;

  cmd_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o    = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o   = (cnt_q == '0);
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign pop_cmd_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

/* sv/tevq_back.sv */
// Back end: sorted event store, time counter, release sequencer, result register.
// Depends on tevq_pkg.
`default_nettype none

module tevq_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tevq_pkg::cmd_t  q_cmd_i,
  input  wire logic            q_empty_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output logic                 result_kind_o,
  output logic [1:0]           status_o,
  output logic [15:0]          released_tag_o,
  output logic [31:0]          released_due_o,
  output logic                 last_o
);
  import tevq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_REL  = 2'b10
  } state_e;

  state_e           state_q, state_d;
  logic [DUE_W-1:0] now_q, now_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             closed_q, closed_d;
  logic [RN_W-1:0]  rel_n_q, rel_n_d;

  logic [DUE_W-1:0] due_q [CAPACITY];
  logic [DUE_W-1:0] due_d [CAPACITY];
  logic [TAG_W-1:0] tag_q [CAPACITY];
  logic [TAG_W-1:0] tag_d [CAPACITY];

  logic             ov_q, ov_d;
  logic             okind_q, okind_d;
  logic [1:0]       ost_q, ost_d;
  logic [TAG_W-1:0] otag_q, otag_d;
  logic [DUE_W-1:0] odue_q, odue_d;
  logic             olast_q, olast_d;

  logic                out_ok;
  logic [CAPACITY-1:0] gt;
  logic [CAPACITY-1:0] at_end;
  logic                head_due, more_due;

  assign out_ok = !ov_q || !out_stall_i;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i]     = (CNT_W'(i) < cnt_q) && (due_q[i] > q_cmd_i.due);
      at_end[i] = (CNT_W'(i) == cnt_q);
    end
  end

  assign head_due = (cnt_q != '0) && (due_q[0] <= now_q);
  assign more_due = (cnt_q > CNT_W'(1)) && (due_q[1] <= now_q) &&
                    ((rel_n_q + RN_W'(1)) < RN_W'(MAX_OUT));

  always_comb begin
    state_d  = state_q;
    now_d    = now_q;
    cnt_d    = cnt_q;
    closed_d = closed_q;
    rel_n_d  = rel_n_q;
    due_d    = due_q;
    tag_d    = tag_q;
    q_pop_o  = 1'b0;
    ov_d     = ov_q && out_stall_i;
    okind_d  = okind_q;
    ost_d    = ost_q;
    otag_d   = otag_q;
    odue_d   = odue_q;
    olast_d  = olast_q;

    case (state_q)
      S_IDLE: begin
        if (!q_empty_i && out_ok) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_SCHED: begin
              ov_d    = 1'b1;
              okind_d = KIND_ACK;
              otag_d  = '0;
              odue_d  = '0;
              olast_d = 1'b1;
              if (closed_q) begin
                ost_d = ST_CLOSED;
              end else if (cnt_q >= CNT_W'(CAPACITY)) begin
                ost_d = ST_FULL;
              end else begin
                ost_d = ST_OK;
                // sorted insert: later entries shift up by one
                for (int i = 0; i < CAPACITY; i++) begin
                  if (gt[i] || at_end[i]) begin
                    due_d[i] = q_cmd_i.due;
                    tag_d[i] = q_cmd_i.tag;
                  end
                end
                for (int i = 1; i < CAPACITY; i++) begin
                  if (gt[i-1]) begin
                    due_d[i] = due_q[i-1];
                    tag_d[i] = tag_q[i-1];
                  end
                end
                cnt_d = cnt_q + CNT_W'(1);
              end
            end
            OP_CLOSE: begin
              closed_d = 1'b1;
              ov_d     = 1'b1;
              okind_d  = KIND_ACK;
              ost_d    = ST_OK;
              otag_d   = '0;
              odue_d   = '0;
              olast_d  = 1'b1;
            end
            OP_TICK: begin
              if (!closed_q) begin
                now_d   = (now_q != '1) ? now_q + DUE_W'(1) : now_q;
                rel_n_d = '0;
                state_d = S_REL;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_REL: begin
        if (!head_due) begin
          state_d = S_IDLE;
        end else if (out_ok) begin
          ov_d    = 1'b1;
          okind_d = KIND_REL;
          ost_d   = ST_OK;
          otag_d  = tag_q[0];
          odue_d  = due_q[0];
          olast_d = !more_due;
          // pop the head
          for (int i = 0; i < CAPACITY - 1; i++) begin
            due_d[i] = due_q[i+1];
            tag_d[i] = tag_q[i+1];
          end
          cnt_d   = cnt_q - CNT_W'(1);
          rel_n_d = rel_n_q + RN_W'(1);
          if (!more_due) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      now_q    <= '0;
      cnt_q    <= '0;
      closed_q <= 1'b0;
      rel_n_q  <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      now_q    <= now_d;
      cnt_q    <= cnt_d;
      closed_q <= closed_d;
      rel_n_q  <= rel_n_d;
      ov_q     <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    due_q   <= due_d;
    tag_q   <= tag_d;
    okind_q <= okind_d;
    ost_q   <= ost_d;
    otag_q  <= otag_d;
    odue_q  <= odue_d;
    olast_q <= olast_d;
  end

  assign out_valid_o    = ov_q;
  assign result_kind_o  = okind_q;
  assign status_o       = ost_q;
  assign released_tag_o = otag_q;
  assign released_due_o = odue_q;
  assign last_o         = olast_q;

endmodule

`default_nettype wire

/* sv/timed_event_queue_core.sv */
// Timed event queue top level: front end, command queue, back end.
// Depends on tevq_pkg, tevq_front, tevq_fifo, tevq_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per command:
//   schedule (due_time_i, event_tag_i), tick, or close. Unused action codes
//   are taken and dropped. Output channel (out_valid_o / out_stall_i) carries
//   acknowledgements and released events; last_o marks the final beat that
//   one command causes.
//   Order: the back end takes a queued command when it is idle and the
//   result register is free; an ack goes into the result register. A tick
//   first advances time, then releases the due events, one per cycle while
//   the receiver does not stall (the head of the sorted store pops each
//   time), then goes back to idle, also when nothing was due.
//   Insertion compares the new due time against every stored entry at once
//   and shifts the later entries up in the same cycle.
//   Reset clears time, the event count and the closed flag; the store holds
//   no valid entries after reset, so no clearing pass is needed.
//   When the receiver stalls, the result register holds its beat; the back
//   end waits, the command queue fills, and then in_stall_o rises.
`default_nettype none

module timed_event_queue_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [31:0] due_time_i,
  input  wire logic [15:0] event_tag_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             result_kind_o,
  output logic [1:0]       status_o,
  output logic [15:0]      released_tag_o,
  output logic [31:0]      released_due_o,
  output logic             last_o
);
  import tevq_pkg::*;

  // front to queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;

  // queue to back
  cmd_t q_pop_cmd;
  logic q_empty;
  logic q_pop;

  // Decode the action and push the command unless the queue is full or the code is unused.
  tevq_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .due_time_i  (due_time_i),
    .event_tag_i (event_tag_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_cmd_o     (q_push_cmd)
  );

  // Hold decoded commands so the front keeps taking beats while the back works.
  tevq_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_cmd_o  (q_pop_cmd),
    .empty_o    (q_empty)
  );

  // Carry out commands against the sorted store and drive results.
  tevq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_cmd_i        (q_pop_cmd),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .status_o       (status_o),
    .released_tag_o (released_tag_o),
    .released_due_o (released_due_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for timed_event_queue_core: directed table, then random traffic.
// Depends on tevq_pkg for widths and codes; the expected beats come from a predictor kept here.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tevq_pkg::*;

  // Code 3 is not defined by the block; it must be dropped with no beats.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 170;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 200_000;
  localparam int REPORT_MAX   = 10;

  // One output beat, in port order.
  typedef struct packed {
    logic             kind;
    logic [1:0]       status;
    logic [TAG_W-1:0] tag;
    logic [DUE_W-1:0] due;
    logic             last;
  } beat_t;

  // One row of the directed table. Where "typed" is set, the row's single
  // acknowledgement is written out by hand; the predictor still tracks state.
  typedef struct packed {
    logic [1:0]       act;
    logic [DUE_W-1:0] due;
    logic [TAG_W-1:0] tag;
    logic             typed;
    logic [1:0]       status;
  } row_t;

  // Opening rows, taken right after reset.
  row_t opening_rows [14] = '{
    '{ACT_TICK,   32'd0,         16'h0000, 1'b0, ST_OK},  // nothing due yet
    '{ACT_SCHED,  32'd0,         16'hFFFF, 1'b1, ST_OK},  // due already
    '{ACT_SCHED,  32'd1,         16'h0000, 1'b1, ST_OK},  // due already
    '{ACT_SCHED,  32'd1,         16'h1234, 1'b1, ST_OK},  // ties with the one above
    '{ACT_SCHED,  32'd3,         16'h00FF, 1'b1, ST_OK},
    '{ACT_SCHED,  32'd2,         16'hFF00, 1'b1, ST_OK},  // lands in front of due 3
    '{ACT_TICK,   32'd0,         16'h0000, 1'b0, ST_OK},  // four releases at once
    '{ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 1'b0, ST_OK},  // dropped silently
    '{ACT_TICK,   32'd0,         16'h0000, 1'b0, ST_OK},
    '{ACT_TICK,   32'd0,         16'h0000, 1'b0, ST_OK},  // empty store
    '{ACT_SCHED,  32'd6,         16'h5A5A, 1'b1, ST_OK},
    '{ACT_SCHED,  32'd5,         16'hA5A5, 1'b1, ST_OK},
    '{ACT_TICK,   32'd0,         16'h0000, 1'b0, ST_OK},
    '{ACT_TICK,   32'd0,         16'h0000, 1'b0, ST_OK}
  };

  // Closing rows, taken once the store has been filled to capacity.
  row_t closing_rows [6] = '{
    '{ACT_SCHED,  32'd0,         16'h0000, 1'b1, ST_FULL},
    '{ACT_CLOSE,  32'd0,         16'h0000, 1'b1, ST_OK},
    '{ACT_SCHED,  32'hFFFF_FFFF, 16'hFFFF, 1'b1, ST_CLOSED},  // closed wins over full
    '{ACT_TICK,   32'd0,         16'h0000, 1'b0, ST_OK},      // frozen, no releases
    '{ACT_CLOSE,  32'd0,         16'h0000, 1'b1, ST_OK},      // second close still acked
    '{ACT_SCHED,  32'd0,         16'h0000, 1'b1, ST_CLOSED}
  };

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic [1:0]       action = ACT_SCHED;
  logic [31:0]      due_time = '0;
  logic [15:0]      event_tag = '0;
  logic             out_stall = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             result_kind;
  logic [1:0]       status;
  logic [15:0]      released_tag;
  logic [31:0]      released_due;
  logic             last;

  // Predicted state of the timer queue.
  logic [DUE_W-1:0] tq_now;
  logic [DUE_W-1:0] tq_due [CAPACITY];
  logic [TAG_W-1:0] tq_tag [CAPACITY];
  int               tq_count;
  logic             tq_closed;

  beat_t awaited_beats [$];
  int    fail_count  = 0;
  int    items_sent  = 0;
  int    cycle_count = 0;
  bit    steady      = 1'b0;  // set: neither side idles

  timed_event_queue_core DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .due_time_i     (due_time),
    .event_tag_i    (event_tag),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_kind_o  (result_kind),
    .status_o       (status),
    .released_tag_o (released_tag),
    .released_due_o (released_due),
    .last_o         (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Append one expected beat behind those already waiting.
  task automatic queue_beat(input beat_t b);
    awaited_beats.insert(awaited_beats.size(), b);
  endtask

  // Work out the beats one accepted item causes and advance the predicted
  // state. With keep cleared, update the state but queue nothing.
  task automatic predict_item(input logic [1:0] act, input logic [DUE_W-1:0] due,
                              input logic [TAG_W-1:0] tag, input bit keep);
    int    pos;
    int    n;
    beat_t b;
    b = '{KIND_ACK, ST_OK, '0, '0, 1'b1};
    case (act)
      ACT_SCHED: begin
        // Closed is checked ahead of full; a refused event leaves the store alone.
        if (tq_closed) begin
          b.status = ST_CLOSED;
        end else if (tq_count >= CAPACITY) begin
          b.status = ST_FULL;
        end else begin
          // Insert behind every entry due at or before the new one, so ties
          // keep arrival order.
          pos = tq_count;
          while (pos > 0 && tq_due[pos-1] > due) pos--;
          for (int i = tq_count; i > pos; i--) begin
            tq_due[i] = tq_due[i-1];
            tq_tag[i] = tq_tag[i-1];
          end
          tq_due[pos] = due;
          tq_tag[pos] = tag;
          tq_count++;
        end
        if (keep) queue_beat(b);
      end
      ACT_CLOSE: begin
        tq_closed = 1'b1;
        if (keep) queue_beat(b);
      end
      ACT_TICK: begin
        if (!tq_closed) begin
          // Advance time, saturating, then pop everything now due from the head.
          if (tq_now != '1) tq_now++;
          n = 0;
          while (n < tq_count && n < MAX_OUT && tq_due[n] <= tq_now) n++;
          for (int k = 0; k < n; k++) begin
            b = '{KIND_REL, ST_OK, tq_tag[k], tq_due[k], (k == n - 1)};
            if (keep) queue_beat(b);
          end
          for (int i = n; i < tq_count; i++) begin
            tq_due[i-n] = tq_due[i];
            tq_tag[i-n] = tq_tag[i];
          end
          tq_count -= n;
        end
      end
      default: ;
    endcase
  endtask

  // Present one beat at a falling edge and hold it until taken. Random idle
  // cycles go in front unless the steady stretch is on.
  task automatic send_beat(input logic [1:0] act, input logic [DUE_W-1:0] due,
                           input logic [TAG_W-1:0] tag);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid  = 1'b1;
    action    = act;
    due_time  = due;
    event_tag = tag;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic issue(input logic [1:0] act, input logic [DUE_W-1:0] due,
                       input logic [TAG_W-1:0] tag);
    predict_item(act, due, tag, 1'b1);
    if (act != ACT_UNUSED) items_sent++;
    send_beat(act, due, tag);
  endtask

  task automatic apply_row(input row_t r);
    if (r.typed) begin
      queue_beat('{KIND_ACK, r.status, '0, '0, 1'b1});
      predict_item(r.act, r.due, r.tag, 1'b0);
      if (r.act != ACT_UNUSED) items_sent++;
      send_beat(r.act, r.due, r.tag);
    end else begin
      issue(r.act, r.due, r.tag);
    end
  endtask

  // Due time near the current time: mostly a few ticks ahead, sometimes
  // already due.
  function automatic logic [DUE_W-1:0] near_due();
    if ($urandom_range(0, 9) < 2) begin
      return (tq_now > 3) ? tq_now - $urandom_range(0, 3) : '0;
    end
    return tq_now + $urandom_range(1, 6);
  endfunction

  function automatic logic [TAG_W-1:0] any_tag();
    return TAG_W'($urandom_range(0, 16'hFFFF));
  endfunction

  task automatic random_traffic();
    int         start;
    int         pick;
    bit         first;
    logic [1:0] noise_act;
    start = items_sent;
    first = 1'b1;
    while (items_sent - start < RANDOM_ITEMS) begin
      // Hold both sides busy through a stretch in the middle of the run.
      steady = (items_sent - start >= 80) && (items_sent - start < 140);
      pick = first ? 55 : $urandom_range(0, 99);
      first = 1'b0;
      if (pick < 50) begin
        // Short burst of schedules, then a few ticks.
        repeat ($urandom_range(1, 5)) issue(ACT_SCHED, near_due(), any_tag());
        repeat ($urandom_range(1, 3)) issue(ACT_TICK, $urandom, any_tag());
      end else if (pick < 62) begin
        // Fill the store, push past full, then issue one to seven ticks.
        while (tq_count < CAPACITY) begin
          issue(ACT_SCHED, near_due(), any_tag());
        end
        repeat ($urandom_range(0, 2)) issue(ACT_SCHED, near_due(), any_tag());
        repeat ($urandom_range(1, 7)) issue(ACT_TICK, $urandom, any_tag());
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) issue(ACT_TICK, $urandom, any_tag());
      end else begin
        // Noise: schedule, tick or the unused code, any field value. Close
        // waits for the closing rows so the store can still be filled.
        case ($urandom_range(0, 2))
          0:       noise_act = ACT_SCHED;
          1:       noise_act = ACT_TICK;
          default: noise_act = ACT_UNUSED;
        endcase
        issue(noise_act, $urandom, any_tag());
      end
    end
    steady = 1'b0;
  endtask

  task automatic note_failure(input string what, input beat_t want, input beat_t seen);
    fail_count++;
    if (fail_count <= REPORT_MAX) begin
      $display("%s: expected kind=%0d status=%0d tag=%h due=%h last=%0d", what,
               want.kind, want.status, want.tag, want.due, want.last);
      $display("    got kind=%0d status=%0d tag=%h due=%h last=%0d",
               seen.kind, seen.status, seen.tag, seen.due, seen.last);
    end
  endtask

  // Receiver stall: random, except during the steady stretch.
  always @(negedge clk) begin
    out_stall = steady ? 1'b0 : ($urandom_range(0, 99) < 33);
  end

  // Compare every taken result beat with the oldest waiting expectation.
  always @(posedge clk) begin
    beat_t seen;
    beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      seen = '{result_kind, status, released_tag, released_due, last};
      if (awaited_beats.size() == 0) begin
        note_failure("result beat with nothing pending", '0, seen);
      end else begin
        want = awaited_beats.pop_front();
        if (seen !== want) note_failure("result beat mismatch", want, seen);
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[timed_event_queue_core] ERROR");
      $finish;
    end
  end

  initial begin
    tq_now    = '0;
    tq_count  = 0;
    tq_closed = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (opening_rows[i]) apply_row(opening_rows[i]);

    random_traffic();

    // Top the store up to capacity, the first event at the latest possible time.
    if (tq_count < CAPACITY) issue(ACT_SCHED, '1, any_tag());
    while (tq_count < CAPACITY) begin
      issue(ACT_SCHED, $urandom | 32'h8000_0000, any_tag());
    end

    foreach (closing_rows[i]) apply_row(closing_rows[i]);

    // Drop valid, drain what is still owed, then give stray beats time to show.
    in_valid = 1'b0;
    while (awaited_beats.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("[timed_event_queue_core] OK");
    end else begin
      $display("[timed_event_queue_core] ERROR");
    end
    $finish;
  end

endmodule
